### rtl/core/ntfjt_pkg.sv
// Package for the note to frequency converter: widths, control struct,
// Q30 ratio tables and the divide-by-twelve helper.
// No dependencies; used by every module in rtl/core.
package ntfjt_pkg;

  localparam int NOTE_FRAC_BITS_DEF = 8;
  localparam int FREQ_FRAC_BITS_DEF = 16;

  localparam int NOTE_INT_W  = 7;
  localparam int F12_W       = 12;
  localparam int Q30_W       = 32;
  localparam int SH_W        = 8;
  localparam int STEP_W      = 4;
  localparam int U_W         = 9;
  localparam int OCT_W       = 5;
  localparam int FREQ_W      = 30;
  localparam int OUT_TDATA_W = 32;
  localparam int V_W         = 41;
  localparam int SV_W        = 64;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0]  CFG_JUST_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_TONIC_NOTE = 1'd1;
  localparam logic [NOTE_INT_W-1:0] TONIC_RESET    = 7'd60;
  localparam logic [V_W-1:0]        A4_HZ          = 41'd440;

  typedef struct packed {
    logic signed [SH_W-1:0] sh;
    logic [F12_W-1:0]       f12;
  } ctl_t;

  typedef struct packed {
    logic [OCT_W-1:0]  q;
    logic [STEP_W-1:0] rem;
  } split_t;

  function automatic logic [Q30_W-1:0] dec_q30(longint unsigned d);
    return Q30_W'(((d << 30) + 64'd500000000) / 64'd1000000000);
  endfunction

  localparam logic [Q30_W-1:0] ET_ROM [16] = '{
    dec_q30(64'd1000000000), dec_q30(64'd1059463094), dec_q30(64'd1122462048),
    dec_q30(64'd1189207115), dec_q30(64'd1259921050), dec_q30(64'd1334839854),
    dec_q30(64'd1414213562), dec_q30(64'd1498307077), dec_q30(64'd1587401052),
    dec_q30(64'd1681792831), dec_q30(64'd1781797436), dec_q30(64'd1887748625),
    32'd0, 32'd0, 32'd0, 32'd0
  };

  localparam logic [Q30_W-1:0] JI_ROM [16] = '{
    32'd1073741824, 32'd1145324612, 32'd1207959552, 32'd1288490189,
    32'd1342177280, 32'd1431655765, 32'd1509949440, 32'd1610612736,
    32'd1717986918, 32'd1789569707, 32'd1932735283, 32'd2013265920,
    32'd0, 32'd0, 32'd0, 32'd0
  };

  localparam logic [Q30_W-1:0] FP_ROM [12] = '{
    dec_q30(64'd1029302237), dec_q30(64'd1014545335), dec_q30(64'd1007246412),
    dec_q30(64'd1003616666), dec_q30(64'd1001806701), dec_q30(64'd1000902943),
    dec_q30(64'd1000451370), dec_q30(64'd1000225659), dec_q30(64'd1000112823),
    dec_q30(64'd1000056410), dec_q30(64'd1000028205), dec_q30(64'd1000014102)
  };

  // Quotient by twelve through a reciprocal; exact for the range 0 to 383.
  function automatic split_t div12(logic [U_W-1:0] u);
    logic [16:0]    p;
    logic [U_W-1:0] q12;
    split_t         s;
    p     = 17'(u) * 17'd171;
    s.q   = OCT_W'(p >> 11);
    q12   = U_W'(s.q) * U_W'(12);
    s.rem = STEP_W'(u - q12);
    return s;
  endfunction

endpackage

### rtl/core/ntfjt_mul_stage.sv
// One pipeline stage of Q2.30 multiplication with rounding to nearest.
// When use_i is low the a operand passes through unchanged.
// Depends on ntfjt_pkg.
module ntfjt_mul_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic                          use_i,
  input  logic [ntfjt_pkg::Q30_W-1:0]   a_i,
  input  logic [ntfjt_pkg::Q30_W-1:0]   b_i,
  input  ntfjt_pkg::ctl_t               ctl_i,
  output logic                          vld_o,
  output logic [ntfjt_pkg::Q30_W-1:0]   r_o,
  output ntfjt_pkg::ctl_t               ctl_o
);

  logic                        vld_r;
  logic [ntfjt_pkg::Q30_W-1:0] r_r, r_nxt;
  ntfjt_pkg::ctl_t             ctl_r;
  logic [63:0]                 prod;

  always_comb begin
    prod  = 64'(a_i) * 64'(b_i) + (64'd1 << 29);
    r_nxt = use_i ? ntfjt_pkg::Q30_W'(prod >> 30) : a_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= r_nxt;
      ctl_r <= ctl_i;
    end
  end

  assign vld_o = vld_r;
  assign r_o   = r_r;
  assign ctl_o = ctl_r;

endmodule

### rtl/core/note_to_frequency_just_tuning.sv
// Note number to frequency converter, equal temperament or 5-limit just
// intonation, built as a 16-stage pipeline that takes one request per cycle
// while the output is not stalled (out_tready high or no result held); the depth is
// set by the chain of thirteen Q30 multiplier stages plus split, scale, shift.
// Reset clears all valid bits, sets just_mode to 0 and tonic_note to 60.
// Depends on ntfjt_pkg and ntfjt_mul_stage.
module note_to_frequency_just_tuning #(
  parameter int NOTE_FRAC_BITS = ntfjt_pkg::NOTE_FRAC_BITS_DEF,
  parameter int FREQ_FRAC_BITS = ntfjt_pkg::FREQ_FRAC_BITS_DEF,
  localparam int NOTE_W     = ntfjt_pkg::NOTE_INT_W + NOTE_FRAC_BITS,
  localparam int IN_TDATA_W = ((NOTE_W + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: note_q8.
  input  logic [IN_TDATA_W-1:0]               in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: freq_q16.
  output logic [ntfjt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Fields from bit 0: saturated.
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [ntfjt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ntfjt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NFP = 12;
  localparam logic signed [ntfjt_pkg::SH_W-1:0] SH_OFS =
    ntfjt_pkg::SH_W'(FREQ_FRAC_BITS - 52);

  logic en;

  // Configuration registers.
  logic                             just_mode_r;
  logic [ntfjt_pkg::NOTE_INT_W-1:0] tonic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      just_mode_r <= 1'b0;
      tonic_r     <= ntfjt_pkg::TONIC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntfjt_pkg::CFG_JUST_MODE:  just_mode_r <= cfg_wdata[0];
        ntfjt_pkg::CFG_TONIC_NOTE: tonic_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: split the interval into octave and step.
  logic [NOTE_W-1:0]                 note;
  logic [ntfjt_pkg::NOTE_INT_W-1:0]  whole;
  logic [NOTE_FRAC_BITS-1:0]         frac;
  logic [ntfjt_pkg::U_W-1:0]         u_note, u_tonic;
  ntfjt_pkg::split_t                 sp, spt;
  logic [5:0]                        base;
  ntfjt_pkg::ctl_t                   s1_ctl_nxt;

  always_comb begin
    note    = in_tdata[NOTE_W-1:0];
    whole   = note[NOTE_W-1 -: ntfjt_pkg::NOTE_INT_W];
    frac    = note[NOTE_FRAC_BITS-1:0];
    u_note  = just_mode_r
            ? ntfjt_pkg::U_W'(whole) - ntfjt_pkg::U_W'(tonic_r) + 9'd132
            : ntfjt_pkg::U_W'(whole) + 9'd63;
    u_tonic = ntfjt_pkg::U_W'(tonic_r) + 9'd63;
    sp      = ntfjt_pkg::div12(u_note);
    spt     = ntfjt_pkg::div12(u_tonic);
    base    = just_mode_r ? 6'(sp.q) + 6'(spt.q) : 6'(sp.q) + 6'd11;
    s1_ctl_nxt.sh  = $signed({2'b00, base}) + SH_OFS;
    s1_ctl_nxt.f12 = ntfjt_pkg::F12_W'(32'(frac) << (12 - NOTE_FRAC_BITS));
  end

  logic                          s1_v_r;
  logic                          s1_just_r;
  logic [ntfjt_pkg::STEP_W-1:0]  s1_step_r, s1_stept_r;
  ntfjt_pkg::ctl_t               s1_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_just_r  <= just_mode_r;
      s1_step_r  <= sp.rem;
      s1_stept_r <= spt.rem;
      s1_ctl_r   <= s1_ctl_nxt;
    end
  end

  // Stage 2: ratio against the tonic in just mode, then one stage per fraction bit.
  logic                        ch_v   [NFP+1];
  logic [ntfjt_pkg::Q30_W-1:0] ch_r   [NFP+1];
  ntfjt_pkg::ctl_t             ch_ctl [NFP+1];

  ntfjt_mul_stage u_tonic_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (s1_v_r),
    .use_i (s1_just_r),
    .a_i   (s1_just_r ? ntfjt_pkg::JI_ROM[s1_step_r] : ntfjt_pkg::ET_ROM[s1_step_r]),
    .b_i   (ntfjt_pkg::ET_ROM[s1_stept_r]),
    .ctl_i (s1_ctl_r),
    .vld_o (ch_v[0]),
    .r_o   (ch_r[0]),
    .ctl_o (ch_ctl[0])
  );

  for (genvar j = 0; j < NFP; j++) begin : g_frac
    ntfjt_mul_stage u_frac_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (ch_v[j]),
      .use_i (ch_ctl[j].f12[NFP-1-j]),
      .a_i   (ch_r[j]),
      .b_i   (ntfjt_pkg::FP_ROM[j]),
      .ctl_i (ch_ctl[j]),
      .vld_o (ch_v[j+1]),
      .r_o   (ch_r[j+1]),
      .ctl_o (ch_ctl[j+1])
    );
  end

  // Scale by the reference pitch.
  logic                          s15_v_r;
  logic [ntfjt_pkg::V_W-1:0]     s15_val_r;
  logic signed [ntfjt_pkg::SH_W-1:0] s15_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s15_v_r <= 1'b0;
    end else if (en) begin
      s15_v_r <= ch_v[NFP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s15_val_r <= ntfjt_pkg::V_W'(ch_r[NFP]) * ntfjt_pkg::A4_HZ;
      s15_sh_r  <= ch_ctl[NFP].sh;
    end
  end

  // Final stage: binary exponent with rounding, then saturation.
  logic [ntfjt_pkg::SH_W-1:0]   sh_inv;
  logic [ntfjt_pkg::SV_W-1:0]   sv_part, sv;
  logic                         sat_nxt;
  logic [ntfjt_pkg::FREQ_W-1:0] freq_nxt;

  always_comb begin
    sh_inv  = ~s15_sh_r;
    sv_part = ntfjt_pkg::SV_W'(s15_val_r) >> sh_inv[ntfjt_pkg::SH_W-2:0];
    if (!s15_sh_r[ntfjt_pkg::SH_W-1]) begin
      sv = ntfjt_pkg::SV_W'(s15_val_r) << s15_sh_r[ntfjt_pkg::SH_W-2:0];
    end else begin
      sv = (sv_part + 64'd1) >> 1;
    end
    sat_nxt  = |sv[ntfjt_pkg::SV_W-1:ntfjt_pkg::FREQ_W];
    freq_nxt = sat_nxt ? '1 : sv[ntfjt_pkg::FREQ_W-1:0];
  end

  logic                         out_v_r;
  logic [ntfjt_pkg::FREQ_W-1:0] out_freq_r;
  logic                         out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s15_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_freq_r <= freq_nxt;
      out_sat_r  <= sat_nxt;
    end
  end

  assign en         = !out_v_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = ntfjt_pkg::OUT_TDATA_W'(out_freq_r);
  assign out_tuser  = out_sat_r;

endmodule

### tb/sv/tb_note_to_frequency_just_tuning.sv
// Self-checking testbench for note_to_frequency_just_tuning, covering equal and just tuning.
// Notes go in, frequencies come out, and each frequency is checked against a directed table
// value or an in-bench fixed-point calculator. Depends on ntfjt_pkg and the RTL under rtl/core.
module tb_note_to_frequency_just_tuning;

  localparam int NOTE_FRAC  = ntfjt_pkg::NOTE_FRAC_BITS_DEF;
  localparam int FREQ_FRAC  = ntfjt_pkg::FREQ_FRAC_BITS_DEF;
  localparam int IN_W       = ((ntfjt_pkg::NOTE_INT_W + NOTE_FRAC + 7) / 8) * 8;
  localparam int NOTE_BITS  = ntfjt_pkg::NOTE_INT_W + NOTE_FRAC;
  localparam int CFG_W      = ntfjt_pkg::CFG_DATA_W;
  localparam int HZ_W       = ntfjt_pkg::FREQ_W;
  localparam longint unsigned HZ_MAX = 64'h3FFF_FFFF;
  localparam int RANDOM_NOTES = 550;

  localparam longint unsigned ET_PPB [12] = '{
    64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
    64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
    64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
  };
  localparam longint unsigned FP_PPB [12] = '{
    64'd1029302237, 64'd1014545335, 64'd1007246412, 64'd1003616666,
    64'd1001806701, 64'd1000902943, 64'd1000451370, 64'd1000225659,
    64'd1000112823, 64'd1000056410, 64'd1000028205, 64'd1000014102
  };
  localparam int JI_NUM [12] = '{1, 16, 9, 6, 5, 4, 45, 3, 8, 5, 9, 15};
  localparam int JI_DEN [12] = '{1, 15, 8, 5, 4, 3, 32, 2, 5, 3, 5, 8};

  typedef enum logic [0:0] {ROW_NOTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [IN_W-1:0]       note;
    logic [CFG_W-1:0]      mode_wdata;
    logic [CFG_W-1:0]      tonic_wdata;
    logic                  known;
    logic [HZ_W-1:0]       freq;
    logic                  clipped;
  } dir_row_t;

  typedef struct {
    logic [IN_W-1:0]   note;
    logic [HZ_W-1:0]   freq;
    logic              clipped;
  } freq_expect_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_tvalid;
  logic                                 in_tready;
  logic [IN_W-1:0]                      in_tdata;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [ntfjt_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                                 out_tuser;
  logic                                 cfg_we;
  logic [ntfjt_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]                     cfg_wdata;

  logic [31:0]       et_q30 [12];
  logic [31:0]       ji_q30 [12];
  logic [31:0]       fp_q30 [12];
  logic              cur_just;
  logic [6:0]        cur_tonic;
  freq_expect_t      pending_freqs [$];
  int                send_idle_pct;
  int                recv_stall_pct;
  int                mismatches;
  int                freqs_checked;
  int                notes_sent;
  int                clipped_seen;
  int                tunings_used;

  dir_row_t dir_table [25] = '{
    '{ROW_NOTE, 16'h4500, 7'h00, 7'd0,   1'b1, 30'd28835840, 1'b0},
    '{ROW_NOTE, 16'h5100, 7'h00, 7'd0,   1'b1, 30'd57671680, 1'b0},
    '{ROW_NOTE, 16'h3900, 7'h00, 7'd0,   1'b1, 30'd14417920, 1'b0},
    '{ROW_NOTE, 16'h0000, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h7FFF, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'hFFFF, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'hC500, 7'h00, 7'd0,   1'b1, 30'd28835840, 1'b0},
    '{ROW_NOTE, 16'h4580, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h00FF, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h4501, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_CFG,  16'h0000, 7'h7F, 7'd69,  1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h4500, 7'h00, 7'd0,   1'b1, 30'd28835840, 1'b0},
    '{ROW_NOTE, 16'h4C00, 7'h00, 7'd0,   1'b1, 30'd43253760, 1'b0},
    '{ROW_NOTE, 16'h4000, 7'h00, 7'd0,   1'b1, 30'd21626880, 1'b0},
    '{ROW_NOTE, 16'h7FFF, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h0000, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_CFG,  16'h0000, 7'h01, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h7FFF, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h0000, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_CFG,  16'h0000, 7'h55, 7'd127, 1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h7FFF, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h0000, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h7A80, 7'h00, 7'd0,   1'b0, 30'd0,        1'b0},
    '{ROW_CFG,  16'h0000, 7'h7E, 7'd60,  1'b0, 30'd0,        1'b0},
    '{ROW_NOTE, 16'h4500, 7'h00, 7'd0,   1'b1, 30'd28835840, 1'b0}
  };

  note_to_frequency_just_tuning DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic void split_octave(input int interval, output int oct, output int semi);
    int u;
    u = interval + 132;
    oct = u / 12 - 11;
    semi = u % 12;
  endfunction

  function automatic void note_to_hz(input logic [IN_W-1:0] word,
                                     output logic [HZ_W-1:0] freq, output logic clipped);
    logic [NOTE_BITS-1:0] note;
    logic [11:0]          f12;
    int                   whole, oct, semi, oct_t, semi_t, exp2, sh;
    longint unsigned      r, v, hz;
    note  = word[NOTE_BITS-1:0];
    whole = int'(note >> NOTE_FRAC);
    f12   = 12'((note & ((1 << NOTE_FRAC) - 1)) << (12 - NOTE_FRAC));
    if (cur_just) begin
      split_octave(int'(cur_tonic) - 69, oct_t, semi_t);
      split_octave(whole - int'(cur_tonic), oct, semi);
      r = q30_mul(ji_q30[semi], et_q30[semi_t]);
      exp2 = oct + oct_t;
    end else begin
      split_octave(whole - 69, oct, semi);
      r = et_q30[semi];
      exp2 = oct;
    end
    for (int j = 0; j < 12; j++) begin
      if (f12[11-j]) r = q30_mul(r, fp_q30[j]);
    end
    v  = 440 * r;
    sh = exp2 + FREQ_FRAC - 30;
    if (sh >= 20) hz = (v != 0) ? HZ_MAX + 1 : 0;
    else if (sh >= 0) hz = v << sh;
    else if (-sh >= 63) hz = 0;
    else hz = (v + (64'd1 << (-sh - 1))) >> (-sh);
    clipped = (hz > HZ_MAX);
    freq = clipped ? HZ_W'(HZ_MAX) : HZ_W'(hz);
  endfunction

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    freq_expect_t e;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_freqs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected frequency %0d with nothing pending", out_tdata[HZ_W-1:0]);
      end else begin
        e = pending_freqs.pop_front();
        freqs_checked++;
        if (out_tuser) clipped_seen++;
        if (out_tdata[HZ_W-1:0] !== e.freq || out_tuser !== e.clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Note 0x%04h: expected freq %0d sat %0b, got freq %0d sat %0b",
                     e.note, e.freq, e.clipped, out_tdata[HZ_W-1:0], out_tuser);
        end
      end
    end
  end

  task automatic send_note(input logic [IN_W-1:0] word, input logic known,
                           input logic [HZ_W-1:0] known_freq, input logic known_clip);
    freq_expect_t e;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e.note = word;
    if (known) begin
      e.freq = known_freq;
      e.clipped = known_clip;
    end else begin
      note_to_hz(word, e.freq, e.clipped);
    end
    pending_freqs.push_back(e);
    notes_sent++;
    @(negedge clk);
  endtask

  // Holds off new requests until the pipeline has returned every pending frequency.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_freqs.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_tuning(input logic [CFG_W-1:0] mode_w,
                            input logic [CFG_W-1:0] tonic_w);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= ntfjt_pkg::CFG_JUST_MODE;
    cfg_wdata <= mode_w;
    @(negedge clk);
    cfg_index <= ntfjt_pkg::CFG_TONIC_NOTE;
    cfg_wdata <= tonic_w;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_just  = mode_w[0];
    cur_tonic = tonic_w;
    tunings_used++;
  endtask

  function automatic logic [IN_W-1:0] random_note();
    if ($urandom_range(0, 3) == 0)
      return {1'($urandom), 7'($urandom), 8'h00};
    return IN_W'($urandom_range(0, (1 << IN_W) - 1));
  endfunction

  initial begin
    int seg_left;
    int per_phase;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_we         = 1'b0;
    cfg_index      = ntfjt_pkg::CFG_JUST_MODE;
    cfg_wdata      = '0;
    cur_just       = 1'b0;
    cur_tonic      = ntfjt_pkg::TONIC_RESET;
    send_idle_pct  = 38;
    recv_stall_pct = 71;
    mismatches     = 0;
    freqs_checked  = 0;
    notes_sent     = 0;
    clipped_seen   = 0;
    tunings_used   = 1;
    for (int k = 0; k < 12; k++) begin
      et_q30[k] = 32'(((ET_PPB[k] << 30) + 64'd500000000) / 64'd1000000000);
      fp_q30[k] = 32'(((FP_PPB[k] << 30) + 64'd500000000) / 64'd1000000000);
      ji_q30[k] = 32'(((longint'(JI_NUM[k]) << 30) + JI_DEN[k] / 2) / JI_DEN[k]);
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG)
        set_tuning(dir_table[i].mode_wdata, dir_table[i].tonic_wdata);
      else
        send_note(dir_table[i].note, dir_table[i].known, dir_table[i].freq,
                  dir_table[i].clipped);
    end

    per_phase = RANDOM_NOTES / 3;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 38 : (phase == 1) ? 71 : 0;
      recv_stall_pct = (phase == 0) ? 71 : (phase == 1) ? 38 : 0;
      seg_left = 0;
      for (int n = 0; n < per_phase + ((phase == 2) ? RANDOM_NOTES % 3 : 0); n++) begin
        if (seg_left == 0) begin
          case ($urandom_range(0, 3))
            0:       set_tuning(7'($urandom), 7'd0);
            1:       set_tuning(7'($urandom), 7'd127);
            default: set_tuning(7'($urandom), 7'($urandom));
          endcase
          seg_left = $urandom_range(15, 45);
        end else if ($urandom_range(0, 49) == 0) begin
          wait_drained();
        end
        send_note(random_note(), 1'b0, '0, 1'b0);
        seg_left--;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_freqs.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    mismatches += pending_freqs.size();
    $display("Checked %0d frequencies for %0d notes across %0d tuning settings.",
             freqs_checked, notes_sent, tunings_used);
    $display("Equal and just tuning with tonic extremes; %0d results were clipped.",
             clipped_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
